FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file (hdec_checker.sv).
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define HDEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdec check failed");

// Implication checked in the next cycle.
`define HDEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdec check failed");

`endif

FILE: rtl/core/hdec_pkg.sv
// Package for the humidity/temperature frame decoder: transfer types,
// byte position codes, CRC-8 and full-scale division helpers. No dependencies.
`timescale 1ns / 1ps

package hdec_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } byte_item_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic               temperature_ok;
        logic               humidity_ok;
        logic [15:0]        raw_temperature;
        logic [15:0]        raw_humidity;
    } result_item_t;

    typedef struct packed {
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic        t_ok;
        logic        h_ok;
    } frame_words_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // floor(x / 65535) for x < 17501 * 65536: x = q0*65535 + (lo + q0)
    function automatic logic [14:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[30:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        if (rem >= {1'b0, FULL_SCALE}) begin
            return q0 + 15'd1;
        end
        return q0;
    endfunction

endpackage

FILE: rtl/core/hdec_frame.sv
// Frame tracker: byte position, running CRC-8, raw words; holds a finished
// frame until the scaler takes it. Depends on hdec_pkg.
`timescale 1ns / 1ps

module hdec_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  hdec_pkg::byte_item_t byte_item,
    input  logic                 fwd_ready,
    output logic                 words_valid,
    output hdec_pkg::frame_words_t words
);
    import hdec_pkg::*;

    pos_t         pos_reg, pos_next, pos_eff;
    logic [7:0]   crc_reg, crc_next;
    logic [15:0]  temp_reg, temp_next;
    logic [15:0]  hum_reg, hum_next;
    logic         tpass_reg, tpass_next;
    frame_words_t words_reg, words_next;
    logic         words_valid_reg, words_valid_next;
    logic         accept;
    logic         load;
    logic [7:0]   b;

    assign byte_stall  = words_valid_reg && !fwd_ready;
    assign accept      = byte_valid && !byte_stall;
    assign b           = byte_item.rx_byte;
    assign pos_eff     = byte_item.frame_start ? POS_T_MSB : pos_reg;
    assign words       = words_reg;
    assign words_valid = words_valid_reg;

    // next position
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            case (pos_eff)
                POS_T_MSB: pos_next = POS_T_LSB;
                POS_T_LSB: pos_next = POS_T_CRC;
                POS_T_CRC: pos_next = POS_H_MSB;
                POS_H_MSB: pos_next = POS_H_LSB;
                POS_H_LSB: pos_next = POS_H_CRC;
                POS_H_CRC: pos_next = POS_T_MSB;
                default:   pos_next = POS_T_LSB;
            endcase
        end
    end

    // datapath updates per position
    always_comb
    begin
        crc_next   = crc_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        tpass_next = tpass_reg;
        words_next = words_reg;
        load       = 1'b0;
        if (accept)
        begin
            case (pos_eff)
                POS_T_LSB:
                begin
                    crc_next  = crc8_update(crc_reg, b);
                    temp_next = {temp_reg[15:8], b};
                end
                POS_T_CRC:
                begin
                    tpass_next = (crc_reg == b);
                    crc_next   = CRC_INIT;
                end
                POS_H_MSB:
                begin
                    crc_next = crc8_update(CRC_INIT, b);
                    hum_next = {b, hum_reg[7:0]};
                end
                POS_H_LSB:
                begin
                    crc_next = crc8_update(crc_reg, b);
                    hum_next = {hum_reg[15:8], b};
                end
                POS_H_CRC:
                begin
                    crc_next         = CRC_INIT;
                    load             = 1'b1;
                    words_next.raw_t = temp_reg;
                    words_next.raw_h = hum_reg;
                    words_next.t_ok  = tpass_reg;
                    words_next.h_ok  = (crc_reg == b);
                end
                default:
                begin
                    crc_next  = crc8_update(CRC_INIT, b);
                    temp_next = {b, temp_reg[7:0]};
                end
            endcase
        end
    end

    always_comb
    begin
        if (load)
        begin
            words_valid_next = 1'b1;
        end
        else if (fwd_ready)
        begin
            words_valid_next = 1'b0;
        end
        else
        begin
            words_valid_next = words_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_T_MSB;
            crc_reg         <= CRC_INIT;
            temp_reg        <= '0;
            hum_reg         <= '0;
            tpass_reg       <= 1'b0;
            words_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            temp_reg        <= temp_next;
            hum_reg         <= hum_next;
            tpass_reg       <= tpass_next;
            words_valid_reg <= words_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

endmodule

FILE: rtl/core/hdec_scale.sv
// Scaler and result register: raw words to centi-units, divide by 65535
// done as shift plus one correction. Depends on hdec_pkg.
`timescale 1ns / 1ps

module hdec_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   words_valid,
    input  hdec_pkg::frame_words_t words,
    output logic                   fwd_ready,
    output logic                   result_valid,
    input  logic                   result_stall,
    output hdec_pkg::result_item_t result_item
);
    import hdec_pkg::*;

    logic         result_valid_reg, result_valid_next;
    result_item_t result_reg, result_next;
    logic [30:0]  t_prod, h_prod;
    logic [14:0]  t_quo, h_quo;
    logic [14:0]  t_centi;

    assign fwd_ready    = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    assign t_prod  = 31'(TEMP_SPAN) * 31'(words.raw_t);
    assign h_prod  = 31'(HUM_SPAN) * 31'(words.raw_h);
    assign t_quo   = div_full_scale(t_prod);
    assign h_quo   = div_full_scale(h_prod);
    assign t_centi = t_quo - TEMP_OFFSET;

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (fwd_ready)
        begin
            result_valid_next = words_valid;
            if (words_valid)
            begin
                result_next.temperature_centi = $signed(t_centi);
                result_next.humidity_centi    = h_quo[13:0];
                result_next.temperature_ok    = words.t_ok;
                result_next.humidity_ok       = words.h_ok;
                result_next.raw_temperature   = words.raw_t;
                result_next.raw_humidity      = words.raw_h;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

FILE: rtl/core/humidity_temperature_frame_decode.sv
// Takes six-byte measurement frames (temperature MSB, LSB, CRC, humidity MSB,
// LSB, CRC), one byte per transfer, and gives one scaled result per frame.
// A byte transfer can be taken every cycle unless the input stalls. After the
// sixth byte, one register holds the finished frame, then the result
// register holds the scaled values. The input stalls only while both of
// these are full and the result side stalls. frame_start restarts a frame.
// Depends on hdec_pkg, hdec_frame, hdec_scale.
`timescale 1ns / 1ps

module humidity_temperature_frame_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  hdec_pkg::byte_item_t   byte_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output hdec_pkg::result_item_t result_item
);
    import hdec_pkg::*;

    frame_words_t words;
    logic         words_valid;
    logic         fwd_ready;

    hdec_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .fwd_ready   (fwd_ready),
        .words_valid (words_valid),
        .words       (words)
    );

    hdec_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .words_valid  (words_valid),
        .words        (words),
        .fwd_ready    (fwd_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

FILE: rtl/core/hdec_checker.sv
// Port-level checks on the frame decoder's result channel, bound to the top.
// Depends on hdec_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hdec_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_stall,
    input hdec_pkg::result_item_t result_item
);
    import hdec_pkg::*;

    logic temp_in_range;

    assign temp_in_range = (result_item.temperature_centi >= -15'sd4500) &&
                           (result_item.temperature_centi <= 15'sd13000);

    `HDEC_ASSERT_NEXT(a_valid_held, result_valid && result_stall, result_valid)
    `HDEC_ASSERT_NEXT(a_item_held, result_valid && result_stall, $stable(result_item))
    `HDEC_ASSERT_NOW(a_hum_range, result_valid, result_item.humidity_centi <= HUM_SPAN)
    `HDEC_ASSERT_NOW(a_temp_range, result_valid, temp_in_range)

endmodule

bind humidity_temperature_frame_decode hdec_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
